// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// All checks sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/wfm_pkg.sv -----
// -----------------------------------------------------------------------------
// wfm_pkg
// Shared types, widths and register codes of the windowed spectrum block.
// -----------------------------------------------------------------------------
package wfm_pkg;

  localparam int unsigned FFT_POINTS_DEF  = 128;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned IN_W            = 16;
  localparam int unsigned MAG_W           = 16;
  localparam int unsigned BIN_W           = 6;
  localparam int unsigned RES_W           = 26;
  localparam int unsigned WIN_W           = 17;
  localparam int unsigned WIN_UNITY       = 32768;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;

  localparam logic REG_APPLY_WINDOW = 1'b0;

  localparam longint          ONE_Q30 = 64'sd1073741824;
  localparam longint unsigned PI_Q32  = 64'd13493037705;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_MSTART,
    ST_MWAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                    start;
    logic signed [RES_W-1:0] re;
    logic signed [RES_W-1:0] im;
  } mag_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] mag;
  } mag_rsp_t;

  function automatic int unsigned tw_bits(input int unsigned sb);
    return (sb < 10) ? 30 : 40 - sb;
  endfunction

  function automatic int unsigned fb_bits(input int unsigned sb);
    return 24 - sb;
  endfunction

endpackage

// ----- hw/rtl/windowed_fft_magnitude_top.sv -----
// Bins: FFT_POINTS/2 bins leave in bin order after the frame_end transaction.
// Throughput: samples enter one per cycle while the block collects (in_ready_o
//   is low from frame_end until the last bin is taken); one complex MAC lane
//   sweeps the sample memory once per bin, plus a 26-step square root.
// Reset: asynchronous; clears control, sample count, apply_window = 1.
// -----------------------------------------------------------------------------
// windowed_fft_magnitude_top
// Hann-windowed DFT magnitude spectrum of complex sample frames.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_fft_magnitude_top import wfm_pkg::*; #(
  parameter int unsigned FFT_POINTS  = FFT_POINTS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  sample_i_i,
  input  logic signed [IN_W-1:0]  sample_q_i,
  input  logic                    frame_end_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [MAG_W-1:0]        magnitude_o,
  output logic [BIN_W-1:0]        bin_index_o,
  output logic                    last_bin_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam int unsigned LOGN  = $clog2(FFT_POINTS);
  localparam int unsigned CNT_W = LOGN + 1;
  localparam int unsigned K_W   = LOGN - 1;
  localparam int unsigned BINS  = FFT_POINTS / 2;
  localparam int unsigned TW    = tw_bits(SAMPLE_BITS);
  localparam int unsigned TWW   = TW + 2;
  localparam int unsigned FB    = fb_bits(SAMPLE_BITS);
  localparam int unsigned SH    = 15 + TW - FB + LOGN;
  localparam int unsigned XW    = SAMPLE_BITS + 16;
  localparam int unsigned PW    = XW + TWW;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned SW_W  = 2 * SAMPLE_BITS;
  localparam int unsigned FW    = SAMPLE_BITS + WIN_W + 1;

  state_e state_q;
  state_e state_d;

  logic                    in_ready;
  logic                    issue;
  logic                    round_en;
  logic                    mag_start;
  logic                    in_fire;
  logic                    out_fire;
  logic                    ram_we;
  logic                    clear_acc;
  logic                    last_k;

  logic [CNT_W-1:0]        count_q;
  logic                    apply_window_q;
  logic [LOGN-1:0]         n_q;
  logic [LOGN-1:0]         idx_q;
  logic [K_W-1:0]          k_q;

  logic                    v1_q;
  logic [LOGN-1:0]         n1_q;
  logic [LOGN-1:0]         idx1_q;
  logic                    v2_q;
  logic signed [XW-1:0]    xr2_q;
  logic signed [XW-1:0]    xi2_q;
  logic signed [TWW-1:0]   c2_q;
  logic signed [TWW-1:0]   s2_q;
  logic                    v3_q;
  logic signed [PW-1:0]    p_rc_q;
  logic signed [PW-1:0]    p_is_q;
  logic signed [PW-1:0]    p_ic_q;
  logic signed [PW-1:0]    p_rs_q;
  logic signed [ACC_W-1:0] acc_re_q;
  logic signed [ACC_W-1:0] acc_im_q;
  logic signed [RES_W-1:0] a_q;
  logic signed [RES_W-1:0] b_q;

  logic                    out_valid_q;
  logic [MAG_W-1:0]        magnitude_q;
  logic [BIN_W-1:0]        bin_q;
  logic                    last_q;

  logic signed [SAMPLE_BITS-1:0] si_ext;
  logic signed [SAMPLE_BITS-1:0] sq_ext;
  logic [SW_W-1:0]               ram_rdata;
  logic signed [SAMPLE_BITS-1:0] rd_i;
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic signed [TWW-1:0]         rom_cos;
  logic signed [TWW-1:0]         rom_sin;
  logic [WIN_W-1:0]              rom_win;
  logic signed [WIN_W:0]         win_s;
  logic signed [FW-1:0]          xr_full;
  logic signed [FW-1:0]          xi_full;
  logic                          in_frame;
  logic signed [PW-1:0]          p_rc;
  logic signed [PW-1:0]          p_is;
  logic signed [PW-1:0]          p_ic;
  logic signed [PW-1:0]          p_rs;

  mag_req_t mag_req;
  mag_rsp_t mag_rsp;

  if (SAMPLE_BITS <= IN_W) begin : g_narrow
    assign si_ext = sample_i_i[SAMPLE_BITS-1:0];
    assign sq_ext = sample_q_i[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign si_ext = SAMPLE_BITS'(sample_i_i);
    assign sq_ext = SAMPLE_BITS'(sample_q_i);
  end

  // round half away from zero on a power-of-two divisor
  function automatic logic signed [RES_W-1:0] rdiv_sh(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag_v;
    logic [ACC_W-1:0] q;
    mag_v = (v < 0) ? unsigned'(-v) : unsigned'(v);
    q     = (mag_v + (ACC_W'(1) << (SH - 1))) >> SH;
    return (v < 0) ? -signed'(q[RES_W-1:0]) : signed'(q[RES_W-1:0]);
  endfunction

  assign in_fire   = in_valid_i && in_ready;
  assign out_fire  = out_valid_q && out_ready_i;
  assign ram_we    = in_fire && (count_q < CNT_W'(FFT_POINTS));
  assign last_k    = (k_q == K_W'(BINS - 1));
  assign clear_acc = (in_fire && frame_end_i) || (out_fire && !last_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: if (in_fire && frame_end_i) state_d = ST_MAC;
      ST_MAC:     if (n_q == LOGN'(FFT_POINTS - 1)) state_d = ST_DRAIN;
      ST_DRAIN:   if (!v1_q && !v2_q && !v3_q) state_d = ST_ROUND;
      ST_ROUND:   state_d = ST_MSTART;
      ST_MSTART:  state_d = ST_MWAIT;
      ST_MWAIT:   if (mag_rsp.done) state_d = ST_OUT;
      ST_OUT: begin
        if (out_fire) begin
          state_d = last_q ? ST_COLLECT : ST_MAC;
        end
      end
      default:    state_d = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    round_en  = 1'b0;
    mag_start = 1'b0;
    unique case (state_q)
      ST_COLLECT: in_ready  = 1'b1;
      ST_MAC:     issue     = 1'b1;
      ST_ROUND:   round_en  = 1'b1;
      ST_MSTART:  mag_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_COLLECT;
      count_q        <= '0;
      apply_window_q <= 1'b1;
      n_q            <= '0;
      idx_q          <= '0;
      k_q            <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      v3_q           <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && (paddr[2] == REG_APPLY_WINDOW)) begin
        apply_window_q <= pwdata[0];
      end
      if (ram_we) begin
        count_q <= count_q + 1'b1;
      end
      if (in_fire && frame_end_i) begin
        n_q   <= '0;
        idx_q <= '0;
        k_q   <= '0;
      end
      if (issue) begin
        n_q   <= n_q + 1'b1;
        idx_q <= idx_q + LOGN'(k_q);
      end
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (state_q == ST_MWAIT && mag_rsp.done) begin
        out_valid_q <= 1'b1;
      end
      if (out_fire) begin
        out_valid_q <= 1'b0;
        if (last_q) begin
          count_q <= '0;
        end else begin
          k_q   <= k_q + 1'b1;
          n_q   <= '0;
          idx_q <= '0;
        end
      end
    end
  end

  wfm_ram #(
    .WIDTH (SW_W),
    .DEPTH (FFT_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[LOGN-1:0]),
    .wdata_i ({si_ext, sq_ext}),
    .raddr_i (n_q),
    .rdata_o (ram_rdata)
  );

  wfm_rom #(
    .FFT_POINTS  (FFT_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rom (
    .tw_idx_i  (idx1_q),
    .win_idx_i (n1_q),
    .cos_o     (rom_cos),
    .sin_o     (rom_sin),
    .win_o     (rom_win)
  );

  assign rd_i     = ram_rdata[SW_W-1:SAMPLE_BITS];
  assign rd_q     = ram_rdata[SAMPLE_BITS-1:0];
  assign win_s    = apply_window_q ? {1'b0, rom_win} : {1'b0, WIN_W'(WIN_UNITY)};
  assign xr_full  = rd_i * win_s;
  assign xi_full  = rd_q * win_s;
  assign in_frame = ({1'b0, n1_q} < count_q);
  assign p_rc     = xr2_q * c2_q;
  assign p_is     = xi2_q * s2_q;
  assign p_ic     = xi2_q * c2_q;
  assign p_rs     = xr2_q * s2_q;

  always_ff @(posedge clk_i) begin
    n1_q   <= n_q;
    idx1_q <= idx_q;
    xr2_q  <= in_frame ? signed'(xr_full[XW-1:0]) : '0;
    xi2_q  <= in_frame ? signed'(xi_full[XW-1:0]) : '0;
    c2_q   <= rom_cos;
    s2_q   <= rom_sin;
    p_rc_q <= p_rc;
    p_is_q <= p_is;
    p_ic_q <= p_ic;
    p_rs_q <= p_rs;
    if (clear_acc) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v3_q) begin
      acc_re_q <= acc_re_q + ACC_W'(p_rc_q) + ACC_W'(p_is_q);
      acc_im_q <= acc_im_q + ACC_W'(p_ic_q) - ACC_W'(p_rs_q);
    end
    if (round_en) begin
      a_q <= rdiv_sh(acc_re_q);
      b_q <= rdiv_sh(acc_im_q);
    end
    if (state_q == ST_MWAIT && mag_rsp.done) begin
      magnitude_q <= mag_rsp.mag;
      bin_q       <= BIN_W'(k_q);
      last_q      <= last_k;
    end
  end

  assign mag_req.start = mag_start;
  assign mag_req.re    = a_q;
  assign mag_req.im    = b_q;

  wfm_mag #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mag_req),
    .rsp_o  (mag_rsp)
  );

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign magnitude_o = magnitude_q;
  assign bin_index_o = bin_q;
  assign last_bin_o  = last_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_APPLY_WINDOW) ? PDATA_W'(apply_window_q) : '0;

  `ASSERT_ALWAYS(a_out_in_state, !out_valid_q || (state_q == ST_OUT), "result outside output state")
  `ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(FFT_POINTS), "sample count overflow")
  `ASSERT_ALWAYS(a_pipe_idle, (state_q != ST_COLLECT) || !(v1_q || v2_q || v3_q), "MAC busy while collecting")
  `ASSERT_NEXT(a_frame_reset, out_fire && last_q, count_q == '0, "count not cleared after frame")

endmodule

// ----- hw/rtl/wfm_ram.sv -----
// -----------------------------------------------------------------------------
// wfm_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module wfm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/wfm_rom.sv -----
// -----------------------------------------------------------------------------
// wfm_rom
// Constant twiddle and Hann window tables built at elaboration.
// -----------------------------------------------------------------------------
module wfm_rom import wfm_pkg::*; #(
  parameter int unsigned FFT_POINTS  = FFT_POINTS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [$clog2(FFT_POINTS)-1:0]      tw_idx_i,
  input  logic [$clog2(FFT_POINTS)-1:0]      win_idx_i,
  output logic signed [tw_bits(SAMPLE_BITS)+1:0] cos_o,
  output logic signed [tw_bits(SAMPLE_BITS)+1:0] sin_o,
  output logic [WIN_W-1:0]                   win_o
);

  localparam int unsigned TW      = tw_bits(SAMPLE_BITS);
  localparam int unsigned TWW     = TW + 2;
  localparam int unsigned TW_SH   = 30 - TW;
  localparam longint      TW_HALF = (TW_SH == 0) ? 0 : (longint'(1) << (TW_SH - 1));

  function automatic longint trig_q30(input longint unsigned u, input logic sel_sin);
    logic [1:0]      quad;
    longint unsigned r;
    longint          x;
    longint          x2;
    longint          tc;
    longint          ts;
    longint          sv;
    longint          res;
    quad = u[31:30];
    r    = u & 64'h3FFF_FFFF;
    x    = longint'((r * PI_Q32) >> 33);
    x2   = (x * x) / ONE_Q30;
    tc   = ONE_Q30;
    ts   = ONE_Q30;
    tc   = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 182;
    ts   = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 210;
    tc   = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 132;
    ts   = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 156;
    tc   = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 90;
    ts   = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 110;
    tc   = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 56;
    ts   = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 72;
    tc   = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 30;
    ts   = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 42;
    tc   = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 12;
    ts   = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 20;
    tc   = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 2;
    ts   = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 6;
    sv = (x * ts) / ONE_Q30;
    case (quad)
      2'd0:    res = sel_sin ? sv : tc;
      2'd1:    res = sel_sin ? tc : -sv;
      2'd2:    res = sel_sin ? -sv : -tc;
      default: res = sel_sin ? -tc : sv;
    endcase
    return res;
  endfunction

  function automatic longint rnd_tw(input longint v);
    longint res;
    if (TW_SH == 0) begin
      res = v;
    end else if (v >= 0) begin
      res = (v + TW_HALF) >>> TW_SH;
    end else begin
      res = -((-v + TW_HALF) >>> TW_SH);
    end
    return res;
  endfunction

  logic signed [TWW-1:0] cos_tab [FFT_POINTS];
  logic signed [TWW-1:0] sin_tab [FFT_POINTS];
  logic [WIN_W-1:0]      win_tab [FFT_POINTS];

  for (genvar n = 0; n < FFT_POINTS; n++) begin : g_tab
    localparam longint unsigned UT =
      ((longint'(n) << 32) + longint'(FFT_POINTS / 2)) / longint'(FFT_POINTS);
    localparam longint unsigned UW =
      ((longint'(n % (FFT_POINTS - 1)) << 32) + longint'((FFT_POINTS - 1) / 2))
      / longint'(FFT_POINTS - 1);
    localparam longint CV = rnd_tw(trig_q30(UT, 1'b0));
    localparam longint SV = rnd_tw(trig_q30(UT, 1'b1));
    localparam longint DV = ONE_Q30 - trig_q30(UW, 1'b0);
    localparam longint WV = ((DV < 0 ? longint'(0) : DV) + 32768) >>> 16;
    assign cos_tab[n] = TWW'(CV);
    assign sin_tab[n] = TWW'(SV);
    assign win_tab[n] = WIN_W'(WV);
  end

  assign cos_o = cos_tab[tw_idx_i];
  assign sin_o = sin_tab[tw_idx_i];
  assign win_o = win_tab[win_idx_i];

endmodule

// ----- hw/rtl/wfm_mag.sv -----
// -----------------------------------------------------------------------------
// wfm_mag
// Magnitude unit: squares, bit-pair integer square root, rounding, saturation.
// -----------------------------------------------------------------------------
module wfm_mag import wfm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mag_req_t req_i,
  output mag_rsp_t rsp_o
);

  localparam int unsigned FB    = fb_bits(SAMPLE_BITS);
  localparam int unsigned SQ_W  = 2 * RES_W;
  localparam int unsigned ITER  = RES_W;
  localparam int unsigned IT_W  = $clog2(ITER);
  localparam int unsigned RND_W = RES_W + 1;

  logic signed [SQ_W-1:0] prod_re;
  logic signed [SQ_W-1:0] prod_im;
  logic [SQ_W-1:0]        sqa_q;
  logic [SQ_W-1:0]        sqb_q;
  logic [SQ_W-1:0]        v_q;
  logic [SQ_W-1:0]        r_q;
  logic [SQ_W-1:0]        bit_q;
  logic [SQ_W-1:0]        trial;
  logic                   load_q;
  logic                   run_q;
  logic                   done_q;
  logic [IT_W-1:0]        it_q;
  logic [RND_W-1:0]       rnd;

  assign prod_re = req_i.re * req_i.re;
  assign prod_im = req_i.im * req_i.im;
  assign trial   = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      load_q <= req_i.start;
      if (load_q) begin
        run_q <= 1'b1;
        it_q  <= '0;
      end else if (run_q) begin
        it_q <= it_q + 1'b1;
        if (it_q == IT_W'(ITER - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqa_q <= unsigned'(prod_re);
      sqb_q <= unsigned'(prod_im);
    end
    if (load_q) begin
      v_q   <= sqa_q + sqb_q;
      r_q   <= '0;
      bit_q <= SQ_W'(1) << (2 * (ITER - 1));
    end else if (run_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  if (FB > 0) begin : g_rnd
    assign rnd = (RND_W'(r_q[RES_W-1:0]) + RND_W'(1 << (FB - 1))) >> FB;
  end else begin : g_nornd
    assign rnd = RND_W'(r_q[RES_W-1:0]);
  end

  assign rsp_o.done = done_q;
  assign rsp_o.mag  = (rnd > RND_W'(2 ** MAG_W - 1)) ? {MAG_W{1'b1}} : rnd[MAG_W-1:0];

endmodule

// ----- tb/sv/testbench.sv -----
// -----------------------------------------------------------------------------
// Windowed FFT magnitude testbench
// Feeds I/Q frames through valid/ready, toggles the Hann window over APB,
// and compares every bin magnitude with an in-bench fixed-point spectrum
// predictor. Directed frames first, then random frames under idle and stall.
// -----------------------------------------------------------------------------
module testbench import wfm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS  = FFT_POINTS_DEF;
  localparam int unsigned NBINS = NPTS / 2;
  localparam int unsigned TWB   = 40 - SAMPLE_BITS_DEF;
  localparam int unsigned FRB   = 24 - SAMPLE_BITS_DEF;
  localparam int unsigned DIVSH = 15 + TWB - FRB;
  localparam int unsigned REG_UNMAPPED = 1;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_e;

  typedef struct {
    logic [MAG_W-1:0] mag;
    logic [BIN_W-1:0] bin;
    logic             last;
  } bin_result_t;

  typedef struct {
    logic signed [IN_W-1:0] si;
    logic signed [IN_W-1:0] sq;
    logic                   fe;
    logic                   win;
    logic                   zero;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic signed [IN_W-1:0] sample_i_i = '0;
  logic signed [IN_W-1:0] sample_q_i = '0;
  logic                   frame_end_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [MAG_W-1:0]       magnitude_o;
  logic [BIN_W-1:0]       bin_index_o;
  logic                   last_bin_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  windowed_fft_magnitude_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  longint      cos_tw [NPTS];
  longint      sin_tw [NPTS];
  longint      hann_rom [NPTS];
  longint      store_i [NPTS];
  longint      store_q [NPTS];
  int unsigned fill_count;
  logic        window_on;
  bin_result_t spectrum_q[$];

  gap_mode_e   gap_mode = GAP_NONE;
  int          stall_hold = 0;
  int          errors = 0;
  int          items_sent = 0;
  int          frames_sent = 0;
  int          bins_checked = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (bin %0d)", what, got, want, bins_checked);
    errors++;
  endtask

  function automatic longint rdiv(input longint v, input longint d);
    if (v >= 0) return (v + d / 2) / d;
    return -((-v + d / 2) / d);
  endfunction

  function automatic void turn_cs(input longint unsigned num, input longint unsigned den,
                                  output longint c, output longint s);
    longint unsigned u64;
    logic [31:0]     u;
    longint unsigned r;
    longint          x, x2, tc, ts, sv;
    u64 = (((num % den) << 32) + den / 2) / den;
    u = u64[31:0];
    r = {34'd0, u[29:0]};
    x = longint'((r * PI_Q32) >> 33);
    x2 = x * x / ONE_Q30;
    tc = ONE_Q30;
    ts = ONE_Q30;
    for (int k = 7; k >= 1; k--) begin
      tc = ONE_Q30 - (x2 * tc / ONE_Q30) / ((2 * k - 1) * (2 * k));
      ts = ONE_Q30 - (x2 * ts / ONE_Q30) / ((2 * k) * (2 * k + 1));
    end
    sv = x * ts / ONE_Q30;
    case (u[31:30])
      2'd0: begin c = tc; s = sv; end
      2'd1: begin c = -sv; s = tc; end
      2'd2: begin c = -tc; s = -sv; end
      default: begin c = sv; s = -tc; end
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic build_tables();
    longint c, s, d;
    for (int n = 0; n < NPTS; n++) begin
      turn_cs(n, NPTS, c, s);
      cos_tw[n] = rdiv(c, 64'sd1 << (30 - TWB));
      sin_tw[n] = rdiv(s, 64'sd1 << (30 - TWB));
      turn_cs(n, NPTS - 1, c, s);
      d = ONE_Q30 - c;
      if (d < 0) d = 0;
      hann_rom[n] = (d + 32768) >>> 16;
    end
  endtask

  task automatic predict_spectrum(input logic signed [IN_W-1:0] si,
                                  input logic signed [IN_W-1:0] sq,
                                  input logic fe, input logic zero);
    longint          xr [NPTS];
    longint          xi [NPTS];
    longint          re, im, a, b, w;
    longint unsigned mag;
    int unsigned     idx;
    bin_result_t     r;
    if (fill_count < NPTS) begin
      store_i[fill_count] = si;
      store_q[fill_count] = sq;
    end
    if (fill_count < 255) fill_count++;
    if (!fe) return;
    for (int n = 0; n < NPTS; n++) begin
      w = window_on ? hann_rom[n] : longint'(WIN_UNITY);
      xr[n] = (n < fill_count) ? store_i[n] * w : 0;
      xi[n] = (n < fill_count) ? store_q[n] * w : 0;
    end
    for (int k = 0; k < NBINS; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < NPTS; n++) begin
        idx = (k * n) % NPTS;
        re += xr[n] * cos_tw[idx] + xi[n] * sin_tw[idx];
        im += xi[n] * cos_tw[idx] - xr[n] * sin_tw[idx];
      end
      a = rdiv(re, longint'(NPTS) << DIVSH);
      b = rdiv(im, longint'(NPTS) << DIVSH);
      mag = int_sqrt(longint'(a * a) + longint'(b * b));
      mag = (mag + (64'd1 << (FRB - 1))) >> FRB;
      if (mag > 65535) mag = 65535;
      r.mag  = zero ? '0 : mag[MAG_W-1:0];
      r.bin  = k[BIN_W-1:0];
      r.last = (k == NBINS - 1);
      spectrum_q.push_back(r);
    end
    fill_count = 0;
  endtask

  task automatic apb_write(input int unsigned idx, input logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx * 4);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input int unsigned idx, output logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'(idx * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    data = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (spectrum_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_window(input logic win);
    logic [PDATA_W-1:0] rd;
    drain();
    apb_write(REG_APPLY_WINDOW, {31'd0, win});
    apb_write(REG_UNMAPPED, $urandom());
    window_on = win;
    apb_read(REG_APPLY_WINDOW, rd);
    if (rd[0] !== win) report_mismatch("apply_window readback", rd[0], win);
  endtask

  task automatic send_sample(input logic signed [IN_W-1:0] si, input logic signed [IN_W-1:0] sq,
                             input logic fe, input logic zero);
    logic rdy;
    @(posedge clk_i);
    while ((gap_mode == GAP_SEND && $urandom_range(99) < 52) ||
           (gap_mode == GAP_BOTH && $urandom_range(99) < 13)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i_i <= si;
    sample_q_i <= sq;
    frame_end_i <= fe;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      if (!rdy) @(posedge clk_i);
    end while (!rdy);
    predict_spectrum(si, sq, fe, zero);
    items_sent++;
    if (fe) frames_sent++;
  endtask

  function automatic logic signed [IN_W-1:0] rand_sample();
    case ($urandom_range(15))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return IN_W'($urandom());
    endcase
  endfunction

  task automatic random_frames(input int unsigned budget);
    int unsigned used, len, p;
    used = 0;
    while (used < budget) begin
      p = $urandom_range(99);
      if (p < 80) len = $urandom_range(16, 1);
      else if (p < 92) len = $urandom_range(127, 17);
      else if (p < 97) len = NPTS;
      else len = $urandom_range(140, NPTS + 1);
      for (int n = 0; n < len; n++)
        send_sample(rand_sample(), rand_sample(), n == len - 1, 1'b0);
      used += len;
    end
  endtask

  stim_row_t directed [20] = '{
    '{16'sh7fff, 16'sh8000, 1'b1, 1'b1, 1'b1},
    '{16'sh8000, 16'sh7fff, 1'b1, 1'b1, 1'b1},
    '{16'sh7fff, 16'sh7fff, 1'b0, 1'b1, 1'b0},
    '{16'sh8000, 16'sh8000, 1'b0, 1'b1, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b0, 1'b1, 1'b0},
    '{16'sh3039, 16'shcafe, 1'b1, 1'b1, 1'b0},
    '{16'sh0001, -16'sd1,   1'b0, 1'b1, 1'b0},
    '{-16'sd1,   16'sh0001, 1'b0, 1'b1, 1'b0},
    '{16'sh7fff, 16'sh0000, 1'b1, 1'b1, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b0, 1'b1},
    '{16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 1'b0},
    '{16'sh8000, 16'sh8000, 1'b1, 1'b0, 1'b0},
    '{16'sh0005, -16'sd7,   1'b0, 1'b0, 1'b0},
    '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, 1'b0},
    '{16'sh5555, 16'shaaaa, 1'b0, 1'b0, 1'b0},
    '{16'sh7fff, 16'sh8000, 1'b1, 1'b0, 1'b0},
    '{16'sh8000, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{16'sh7fff, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{16'sh8000, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{16'sh7fff, 16'sh0000, 1'b1, 1'b0, 1'b0}
  };

  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (gap_mode)
        GAP_RECV: out_ready_i <= $urandom_range(99) >= 52;
        GAP_BOTH: out_ready_i <= $urandom_range(99) >= 13;
        default:  out_ready_i <= 1'b1;
      endcase
    end
  end

  always @(negedge clk_i) begin
    bin_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (spectrum_q.size() == 0) begin
        report_mismatch("unexpected bin", bin_index_o, -1);
      end else begin
        want = spectrum_q.pop_front();
        if (magnitude_o !== want.mag) report_mismatch("magnitude", magnitude_o, want.mag);
        if (bin_index_o !== want.bin) report_mismatch("bin_index", bin_index_o, want.bin);
        if (last_bin_o !== want.last) report_mismatch("last_bin", last_bin_o, want.last);
      end
      bins_checked++;
    end
  end

  initial begin
    #300_000_000;
    $display("timeout with %0d bins outstanding", spectrum_q.size());
    $display("testbench: errors");
    $finish;
  end

  initial begin
    build_tables();
    fill_count = 0;
    window_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed[r]) begin
      if (directed[r].win !== window_on) set_window(directed[r].win);
      send_sample(directed[r].si, directed[r].sq, directed[r].fe, directed[r].zero);
    end

    gap_mode = GAP_NONE;
    set_window(1'b1);
    random_frames(100);
    gap_mode = GAP_SEND;
    set_window(1'b0);
    random_frames(100);
    gap_mode = GAP_RECV;
    set_window(1'b1);
    random_frames(100);
    gap_mode = GAP_BOTH;
    set_window(1'b0);
    random_frames(100);
    gap_mode = GAP_NONE;
    set_window(1'b1);
    stall_hold = 25000;
    random_frames(100);

    @(posedge clk_i);
    in_valid_i <= 1'b0;
    drain();
    repeat (300) @(posedge clk_i);
    $display("covered %0d samples in %0d frames, %0d bins compared", items_sent, frames_sent,
             bins_checked);
    $display("window on and off, sender gaps, receiver stalls and a long output hold-off");
    if (errors == 0 && spectrum_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
